// ===== hdl/assert_macros.svh =====
// assertion helpers used by mode7_floor_texel_address
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define M7_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain condition checked on every clock edge out of reset
`define M7_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== hdl/m7fta_pkg.sv =====
// types and constants for the mode 7 floor texel address block
// no dependencies; used by the channel interfaces and mode7_floor_texel_address
`timescale 1ns / 1ps

package m7fta_pkg;

    localparam int PIX_W      = 10;
    localparam int TEXEL_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH   = 3'd0,
        REG_SCALE_X = 3'd1,
        REG_HORIZON = 3'd2,
        REG_POS_X   = 3'd3,
        REG_POS_Y   = 3'd4,
        REG_COS     = 3'd5,
        REG_SIN     = 3'd6
    } cfg_reg_t;

    // register reset values
    localparam logic [19:0]        RST_DEPTH   = 20'd4120;
    localparam logic [15:0]        RST_SCALE_X = 16'd412;
    localparam logic signed [10:0] RST_HORIZON = -11'sd90;
    localparam logic signed [15:0] RST_POS_X   = 16'sd300;
    localparam logic signed [15:0] RST_POS_Y   = 16'sd150;
    localparam logic signed [15:0] RST_COS     = 16'sd16384;
    localparam logic signed [15:0] RST_SIN     = 16'sd0;

    typedef logic signed [TEXEL_W-1:0] texel_t;

    // internal datapath widths
    localparam int DIST_W  = 20;   // row distance
    localparam int MAG_W   = 21;   // step magnitude before and after division
    localparam int STEP_W  = 22;   // signed step
    localparam int DPROD_W = 37;   // distance times sin or cos
    localparam int WPROD_W = 34;   // texture width or column times step
    localparam int Q14_W   = 50;   // row start in q14
    localparam int X0_W    = 36;   // row start after truncation
    localparam int TX_W    = 37;   // texel before saturation

    // saturate a wide texel coordinate to the output range
    function automatic texel_t sat_texel(input logic signed [TX_W-1:0] v);
        logic signed [TX_W-1:0] hi;
        logic signed [TX_W-1:0] lo;
        hi = TX_W'(texel_t'({1'b0, {(TEXEL_W-1){1'b1}}}));
        lo = TX_W'(texel_t'({1'b1, {(TEXEL_W-1){1'b0}}}));
        if (v > hi)
            return texel_t'({1'b0, {(TEXEL_W-1){1'b1}}});
        else if (v < lo)
            return texel_t'({1'b1, {(TEXEL_W-1){1'b0}}});
        else
            return v[TEXEL_W-1:0];
    endfunction

endpackage

// ===== hdl/m7fta_if.sv =====
// valid/ready channel interfaces: pixel in, texel out, register writes
// depends on m7fta_pkg
`timescale 1ns / 1ps

interface m7fta_pix_if;
    import m7fta_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface m7fta_texel_if;
    import m7fta_pkg::*;
    logic             valid;
    logic             ready;
    texel_t           texel_x;
    texel_t           texel_y;
    logic             below_horizon;
    logic             in_bounds;
    logic [PIX_W-1:0] out_col;
    logic [PIX_W-1:0] out_row;
    modport source (output valid, texel_x, texel_y, below_horizon, in_bounds,
                    out_col, out_row, input ready);
    modport sink   (input valid, texel_x, texel_y, below_horizon, in_bounds,
                    out_col, out_row, output ready);
endinterface

interface m7fta_cfg_if;
    import m7fta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/m7fta_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with side payload
// no package dependency; instantiated by mode7_floor_texel_address
`timescale 1ns / 1ps

module m7fta_div #(
    parameter int NW = 20,
    parameter int DW = 10,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vld_prev;
        logic [DW-1:0] rem_prev;
        logic [NW-1:0] num_prev;
        logic [NW-1:0] quo_prev;
        logic [DW-1:0] den_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        // previous stage or the divider inputs
        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign num_prev  = num;
            assign quo_prev  = '0;
            assign den_prev  = den;
            assign side_prev = side;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign num_prev  = num_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // trial subtract of the next numerator bit
        assign trial = {rem_prev, num_prev[NW-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign ge    = (trial >= {1'b0, den_prev});

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                num_reg[k]  <= num_prev << 1;
                quo_reg[k]  <= {quo_prev[NW-2:0], ge};
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// ===== hdl/mode7_floor_texel_address.sv =====
// throughput: one pixel per cycle while the output is not stalled; two
// restoring dividers, one bit per stage, set the depth (20 stages for row
// distance, 21 for the per-column step)
// a stalled output holds the whole pipeline, empty stages included
// reset: rst_n clears all valid bits and loads register reset values
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mode7_floor_texel_address #(
    parameter int TEX_WIDTH  = 512,
    parameter int TEX_HEIGHT = 512
) (
    input logic        clk,
    input logic        rst_n,
    m7fta_pix_if.sink     pix,
    m7fta_texel_if.source texel,
    m7fta_cfg_if.sink     cfg
);
    import m7fta_pkg::*;

    localparam logic signed [11:0]   TEX_W_S   = 12'(TEX_WIDTH);
    localparam logic signed [TX_W-1:0] TX_LIMX = TX_W'(TEX_WIDTH - 1);
    localparam logic signed [TX_W-1:0] TX_LIMY = TX_W'(TEX_HEIGHT - 1);
    localparam int S1_SW = 2 * PIX_W + 1;
    localparam int S2_SW = 2 * PIX_W + 2 + 2 * DPROD_W;

    // configuration registers
    logic [19:0]        depth_reg;
    logic [15:0]        scale_x_reg;
    logic signed [10:0] horizon_reg;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;

    logic en;

    assign cfg.ready = 1'b1;
    assign en        = !texel.valid || texel.ready;
    assign pix.ready = en;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= RST_DEPTH;
            scale_x_reg <= RST_SCALE_X;
            horizon_reg <= RST_HORIZON;
            pos_x_reg   <= RST_POS_X;
            pos_y_reg   <= RST_POS_Y;
            cos_reg     <= RST_COS;
            sin_reg     <= RST_SIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEPTH:   depth_reg   <= cfg.data;
                REG_SCALE_X: scale_x_reg <= cfg.data[15:0];
                REG_HORIZON: horizon_reg <= cfg.data[10:0];
                REG_POS_X:   pos_x_reg   <= cfg.data[15:0];
                REG_POS_Y:   pos_y_reg   <= cfg.data[15:0];
                REG_COS:     cos_reg     <= cfg.data[15:0];
                REG_SIN:     sin_reg     <= cfg.data[15:0];
                default:     ;
            endcase
        end
    end

    // stage 0: row relative to horizon and draw test
    logic             s0_vld_reg;
    logic [PIX_W-1:0] s0_col_reg;
    logic [PIX_W-1:0] s0_row_reg;
    logic             s0_drawn_reg;
    logic [PIX_W:0]   s0_rel_reg;
    logic signed [11:0] rel;
    logic             drawn;

    assign rel   = $signed({2'b00, pix.pixel_row}) + 12'(horizon_reg);
    assign drawn = (rel > 12'sd0) && (32'(pix.pixel_row) < TEX_HEIGHT)
                   && (32'(pix.pixel_col) < TEX_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_col_reg   <= pix.pixel_col;
            s0_row_reg   <= pix.pixel_row;
            s0_drawn_reg <= drawn;
            s0_rel_reg   <= drawn ? rel[PIX_W:0] : (PIX_W+1)'(1);
        end
    end

    // row distance divider
    logic              d1_vld;
    logic [DIST_W-1:0] d1_dist;
    logic [S1_SW-1:0]  d1_side;

    m7fta_div #(.NW(DIST_W), .DW(PIX_W+1), .SW(S1_SW)) u_dist_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s0_vld_reg),
        .num      (depth_reg),
        .den      (s0_rel_reg),
        .side     ({s0_col_reg, s0_row_reg, s0_drawn_reg}),
        .out_valid(d1_vld),
        .quo      (d1_dist),
        .side_out (d1_side)
    );

    // stage 1: distance times sin and cos
    logic                      s1_vld_reg;
    logic [MAG_W-1:0]          s1_mx_reg;
    logic [MAG_W-1:0]          s1_my_reg;
    logic signed [DPROD_W-1:0] s1_dcos_reg;
    logic signed [DPROD_W-1:0] s1_dsin_reg;
    logic                      s1_negx_reg;
    logic                      s1_negy_reg;
    logic [S1_SW-1:0]          s1_side_reg;
    logic [16:0]               sin_mag;
    logic [16:0]               cos_mag;
    logic [DPROD_W-1:0]        px;
    logic [DPROD_W-1:0]        py;
    logic signed [DPROD_W-1:0] dcos;
    logic signed [DPROD_W-1:0] dsin;

    assign sin_mag = sin_reg[15] ? 17'd0 - 17'(sin_reg) : 17'(sin_reg);
    assign cos_mag = cos_reg[15] ? 17'd0 - 17'(cos_reg) : 17'(cos_reg);
    assign px      = d1_dist * sin_mag;
    assign py      = d1_dist * cos_mag;
    assign dcos    = $signed({1'b0, d1_dist}) * cos_reg;
    assign dsin    = $signed({1'b0, d1_dist}) * sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mx_reg   <= px[MAG_W+13:14];
            s1_my_reg   <= py[MAG_W+13:14];
            s1_dcos_reg <= dcos;
            s1_dsin_reg <= dsin;
            s1_negx_reg <= !sin_reg[15];
            s1_negy_reg <= cos_reg[15];
            s1_side_reg <= d1_side;
        end
    end

    // per-column step dividers
    logic             sx_vld;
    logic             sy_vld;
    logic [MAG_W-1:0] sx_mag;
    logic [MAG_W-1:0] sy_mag;
    logic [S2_SW-1:0] sx_side;
    logic             sy_neg;
    logic [15:0]      scale_eff;

    assign scale_eff = (scale_x_reg == 16'd0) ? 16'd1 : scale_x_reg;

    m7fta_div #(.NW(MAG_W), .DW(16), .SW(S2_SW)) u_stepx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s1_vld_reg),
        .num      (s1_mx_reg),
        .den      (scale_eff),
        .side     ({s1_side_reg, s1_negx_reg, s1_dcos_reg, s1_dsin_reg}),
        .out_valid(sx_vld),
        .quo      (sx_mag),
        .side_out (sx_side)
    );

    m7fta_div #(.NW(MAG_W), .DW(16), .SW(1)) u_stepy_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s1_vld_reg),
        .num      (s1_my_reg),
        .den      (scale_eff),
        .side     (s1_negy_reg),
        .out_valid(sy_vld),
        .quo      (sy_mag),
        .side_out (sy_neg)
    );

    // stage 2: signed steps
    logic                      s2_vld_reg;
    logic signed [STEP_W-1:0]  s2_stx_reg;
    logic signed [STEP_W-1:0]  s2_sty_reg;
    logic signed [DPROD_W-1:0] s2_dcos_reg;
    logic signed [DPROD_W-1:0] s2_dsin_reg;
    logic [PIX_W-1:0]          s2_col_reg;
    logic [PIX_W-1:0]          s2_row_reg;
    logic                      s2_drawn_reg;
    logic signed [STEP_W-1:0]  stx_pos;
    logic signed [STEP_W-1:0]  sty_pos;

    assign stx_pos = $signed({1'b0, sx_mag});
    assign sty_pos = $signed({1'b0, sy_mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= sx_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_stx_reg   <= sx_side[2*DPROD_W] ? -stx_pos : stx_pos;
            s2_sty_reg   <= sy_neg ? -sty_pos : sty_pos;
            s2_dsin_reg  <= sx_side[DPROD_W-1:0];
            s2_dcos_reg  <= sx_side[2*DPROD_W-1:DPROD_W];
            s2_drawn_reg <= sx_side[2*DPROD_W+1];
            s2_row_reg   <= sx_side[2*DPROD_W+1+PIX_W:2*DPROD_W+2];
            s2_col_reg   <= sx_side[S2_SW-1:2*DPROD_W+2+PIX_W];
        end
    end

    // stage 3: width and column products
    logic                      s3_vld_reg;
    logic signed [WPROD_W-1:0] s3_wsx_reg;
    logic signed [WPROD_W-1:0] s3_wsy_reg;
    logic signed [WPROD_W-1:0] s3_csx_reg;
    logic signed [WPROD_W-1:0] s3_csy_reg;
    logic signed [DPROD_W-1:0] s3_dcos_reg;
    logic signed [DPROD_W-1:0] s3_dsin_reg;
    logic [PIX_W-1:0]          s3_col_reg;
    logic [PIX_W-1:0]          s3_row_reg;
    logic                      s3_drawn_reg;
    logic signed [11:0]        col2;

    assign col2 = $signed({1'b0, s2_col_reg, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_wsx_reg   <= TEX_W_S * s2_stx_reg;
            s3_wsy_reg   <= TEX_W_S * s2_sty_reg;
            s3_csx_reg   <= col2 * s2_stx_reg;
            s3_csy_reg   <= col2 * s2_sty_reg;
            s3_dcos_reg  <= s2_dcos_reg;
            s3_dsin_reg  <= s2_dsin_reg;
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
            s3_drawn_reg <= s2_drawn_reg;
        end
    end

    // stage 4: row start in q14
    logic                      s4_vld_reg;
    logic signed [Q14_W-1:0]   s4_qx_reg;
    logic signed [Q14_W-1:0]   s4_qy_reg;
    logic signed [WPROD_W-1:0] s4_csx_reg;
    logic signed [WPROD_W-1:0] s4_csy_reg;
    logic [PIX_W-1:0]          s4_col_reg;
    logic [PIX_W-1:0]          s4_row_reg;
    logic                      s4_drawn_reg;
    logic signed [WPROD_W:0]   basex;
    logic signed [WPROD_W:0]   basey;

    assign basex = (WPROD_W+1)'(pos_x_reg) - (WPROD_W+1)'(s3_wsx_reg);
    assign basey = (WPROD_W+1)'(pos_y_reg) - (WPROD_W+1)'(s3_wsy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_qx_reg    <= Q14_W'($signed({basex, 14'd0})) + Q14_W'(s3_dcos_reg);
            s4_qy_reg    <= Q14_W'($signed({basey, 14'd0})) + Q14_W'(s3_dsin_reg);
            s4_csx_reg   <= s3_csx_reg;
            s4_csy_reg   <= s3_csy_reg;
            s4_col_reg   <= s3_col_reg;
            s4_row_reg   <= s3_row_reg;
            s4_drawn_reg <= s3_drawn_reg;
        end
    end

    // stage 5: truncate row start toward zero
    logic                      s5_vld_reg;
    logic signed [X0_W-1:0]    s5_x0_reg;
    logic signed [X0_W-1:0]    s5_y0_reg;
    logic signed [WPROD_W-1:0] s5_csx_reg;
    logic signed [WPROD_W-1:0] s5_csy_reg;
    logic [PIX_W-1:0]          s5_col_reg;
    logic [PIX_W-1:0]          s5_row_reg;
    logic                      s5_drawn_reg;
    logic                      rndx;
    logic                      rndy;

    assign rndx = s4_qx_reg[Q14_W-1] && (s4_qx_reg[13:0] != 14'd0);
    assign rndy = s4_qy_reg[Q14_W-1] && (s4_qy_reg[13:0] != 14'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_x0_reg    <= $signed(s4_qx_reg[Q14_W-1:14]) + $signed({{(X0_W-1){1'b0}}, rndx});
            s5_y0_reg    <= $signed(s4_qy_reg[Q14_W-1:14]) + $signed({{(X0_W-1){1'b0}}, rndy});
            s5_csx_reg   <= s4_csx_reg;
            s5_csy_reg   <= s4_csy_reg;
            s5_col_reg   <= s4_col_reg;
            s5_row_reg   <= s4_row_reg;
            s5_drawn_reg <= s4_drawn_reg;
        end
    end

    // stage 6: add column offset
    logic                   s6_vld_reg;
    logic signed [TX_W-1:0] s6_tx_reg;
    logic signed [TX_W-1:0] s6_ty_reg;
    logic [PIX_W-1:0]       s6_col_reg;
    logic [PIX_W-1:0]       s6_row_reg;
    logic                   s6_drawn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (en)
            s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_tx_reg    <= TX_W'(s5_x0_reg) + TX_W'(s5_csx_reg);
            s6_ty_reg    <= TX_W'(s5_y0_reg) + TX_W'(s5_csy_reg);
            s6_col_reg   <= s5_col_reg;
            s6_row_reg   <= s5_row_reg;
            s6_drawn_reg <= s5_drawn_reg;
        end
    end

    // stage 7: bounds, saturation and output register
    logic   out_vld_reg;
    texel_t out_tx_reg;
    texel_t out_ty_reg;
    logic   out_drawn_reg;
    logic   out_inb_reg;
    logic [PIX_W-1:0] out_col_reg;
    logic [PIX_W-1:0] out_row_reg;
    logic   inb;

    assign inb = s6_drawn_reg && (s6_tx_reg > 0) && (s6_tx_reg < TX_LIMX)
                 && (s6_ty_reg > 0) && (s6_ty_reg < TX_LIMY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= s6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tx_reg    <= s6_drawn_reg ? sat_texel(s6_tx_reg) : '0;
            out_ty_reg    <= s6_drawn_reg ? sat_texel(s6_ty_reg) : '0;
            out_drawn_reg <= s6_drawn_reg;
            out_inb_reg   <= inb;
            out_col_reg   <= s6_col_reg;
            out_row_reg   <= s6_row_reg;
        end
    end

    assign texel.valid         = out_vld_reg;
    assign texel.texel_x       = out_tx_reg;
    assign texel.texel_y       = out_ty_reg;
    assign texel.below_horizon = out_drawn_reg;
    assign texel.in_bounds     = out_inb_reg;
    assign texel.out_col       = out_col_reg;
    assign texel.out_row       = out_row_reg;

    // checks
    `M7_ASSERT_ALWAYS(a_step_div_aligned, sx_vld == sy_vld, "step dividers out of step")
    `M7_ASSERT_IMP(a_hidden_zero, texel.valid && !texel.below_horizon,
        texel.texel_x == '0 && texel.texel_y == '0 && !texel.in_bounds,
        "hidden pixel has nonzero texel")
    `M7_ASSERT_IMP(a_inb_range, texel.valid && texel.in_bounds,
        texel.below_horizon && texel.texel_x > 0 && 32'(texel.texel_x) < TEX_WIDTH - 1,
        "in-bounds texel outside texture")
    `M7_ASSERT_IMP(a_drawn_col, texel.valid && texel.below_horizon,
        32'(texel.out_col) < TEX_WIDTH && 32'(texel.out_row) < TEX_HEIGHT,
        "drawn pixel outside screen area")

endmodule
